// ----- rtl/mau_pkg.sv -----
package mau_pkg;

  localparam int WIDTH = 32;

  localparam logic [WIDTH-1:0] MODULUS_RESET = 32'd4294967291;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_INV = 3'd4;
  localparam logic [2:0] MODE_NEG = 3'd5;

endpackage

// ----- rtl/modular_arithmetic_unit_top.sv -----
// Modular ALU: add, subtract, multiply, divide, inverse and negate modulo a
// configured modulus.
// Input channel in_valid/in_ready carries mode and two operands; result
// channel out_valid/out_ready carries residue and the no_inverse flag.
// cfg_wr_en/cfg_wr_data write the modulus; write only while the unit is idle.
// One word in, one word out, one word at a time.
// Steps: both operands are first reduced (one bit a cycle), then
//   add, subtract, negate: finished in the operation state;
//   multiply: double and add, a double step and an add step per operand bit;
//   inverse: extended Euclid with a shift-subtract divider, one quotient bit a cycle;
//   divide: inverse followed by the multiply.
// A new word is taken as soon as the previous result sits in the output
// register; the unit only waits at the end if that register is still full.
// Reset sets the modulus to 4294967291 and empties the unit.
// A stalled receiver holds the result steady until out_ready.
module modular_arithmetic_unit_top
  import mau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_mode,
  input  logic [WIDTH-1:0] in_operand_a,
  input  logic [WIDTH-1:0] in_operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_residue,
  output logic             out_no_inverse,
  input  logic             cfg_wr_en,
  input  logic [WIDTH-1:0] cfg_wr_data
);

  localparam int CW = $clog2(WIDTH);
  localparam int TW = WIDTH + 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RED   = 4'd1;
  localparam logic [3:0] ST_OP    = 4'd2;
  localparam logic [3:0] ST_SETUP = 4'd3;
  localparam logic [3:0] ST_SH    = 4'd4;
  localparam logic [3:0] ST_SUB   = 4'd5;
  localparam logic [3:0] ST_NEXT  = 4'd6;
  localparam logic [3:0] ST_FIX   = 4'd7;
  localparam logic [3:0] ST_MDBL  = 4'd8;
  localparam logic [3:0] ST_MADD  = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0]       state_r;
  logic [WIDTH-1:0] mod_r;
  logic [2:0]       mode_r;
  logic [WIDTH-1:0] sa_r, sb_r, a_r, b_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] r0_r, r1_r, rem_r;
  logic [TW-1:0]    t0_r, t1_r, tn_r;
  logic [WIDTH:0]   d_r;
  logic [CW-1:0]    k_r;
  logic [WIDTH-1:0] p_r;
  logic [WIDTH-1:0] res_r;
  logic             err_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_residue_r;
  logic             out_err_r;

  logic [WIDTH:0]   ra2, rb2, ra_nxt, rb_nxt;
  logic [WIDTH:0]   add_s, p2, padd;
  logic [TW-1:0]    t1_sh, t_fix;
  logic [WIDTH-1:0] inv_v;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_residue    = out_residue_r;
  assign out_no_inverse = out_err_r;

  always_comb begin
    ra2    = {a_r, sa_r[WIDTH-1]};
    rb2    = {b_r, sb_r[WIDTH-1]};
    ra_nxt = (ra2 >= {1'b0, mod_r}) ? ra2 - {1'b0, mod_r} : ra2;
    rb_nxt = (rb2 >= {1'b0, mod_r}) ? rb2 - {1'b0, mod_r} : rb2;
    add_s  = {1'b0, a_r} + {1'b0, b_r};
    p2     = {p_r, 1'b0};
    padd   = {1'b0, p_r} + {1'b0, a_r};
    // t1 scaled by the weight of the current quotient bit (2^k), exact modulo 2^TW
    t1_sh  = t1_r << k_r;
    t_fix  = t0_r[TW-1] ? t0_r + {2'b00, mod_r} : t0_r;
    inv_v  = (t_fix >= {2'b00, mod_r}) ? t_fix[WIDTH-1:0] - mod_r : t_fix[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mod_r       <= MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mod_r <= cfg_wr_data;
      // a load in ST_DONE takes over the clear
      if (out_valid_r && out_ready && state_r != ST_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            sa_r    <= in_operand_a;
            sb_r    <= in_operand_b;
            a_r     <= '0;
            b_r     <= '0;
            cnt_r   <= CW'(WIDTH - 1);
            state_r <= ST_RED;
          end
        end
        ST_RED: begin
          a_r  <= ra_nxt[WIDTH-1:0];
          b_r  <= rb_nxt[WIDTH-1:0];
          sa_r <= {sa_r[WIDTH-2:0], 1'b0};
          sb_r <= {sb_r[WIDTH-2:0], 1'b0};
          if (cnt_r == '0) state_r <= ST_OP;
          else cnt_r <= cnt_r - CW'(1);
        end
        ST_OP: begin
          err_r <= 1'b0;
          if (mod_r == '0) begin
            res_r   <= '0;
            p_r     <= '0;
            state_r <= ST_DONE;
          end else begin
            unique case (mode_r)
              MODE_ADD: begin
                res_r   <= (add_s >= {1'b0, mod_r}) ?
                           add_s[WIDTH-1:0] - mod_r : add_s[WIDTH-1:0];
                state_r <= ST_DONE;
              end
              MODE_SUB: begin
                res_r   <= a_r - b_r + ((a_r < b_r) ? mod_r : '0);
                state_r <= ST_DONE;
              end
              MODE_NEG: begin
                res_r   <= (a_r == '0) ? '0 : mod_r - a_r;
                state_r <= ST_DONE;
              end
              MODE_MUL: begin
                p_r     <= '0;
                cnt_r   <= CW'(WIDTH - 1);
                state_r <= ST_MDBL;
              end
              MODE_DIV, MODE_INV: begin
                res_r   <= '0;
                r0_r    <= mod_r;
                r1_r    <= (mode_r == MODE_DIV) ? b_r : a_r;
                t0_r    <= '0;
                t1_r    <= TW'(1);
                state_r <= ST_SETUP;
              end
              default: begin
                res_r   <= '0;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_SETUP: begin
          if (r1_r == '0) begin
            state_r <= ST_FIX;
          end else begin
            d_r     <= {1'b0, r1_r};
            k_r     <= '0;
            rem_r   <= r0_r;
            tn_r    <= t0_r;
            state_r <= ST_SH;
          end
        end
        ST_SH: begin
          // align divisor under the remainder's top bit
          if ({d_r[WIDTH-1:0], 1'b0} <= {1'b0, rem_r}) begin
            d_r <= {d_r[WIDTH-1:0], 1'b0};
            k_r <= k_r + CW'(1);
          end else begin
            state_r <= ST_SUB;
          end
        end
        ST_SUB: begin
          if (d_r <= {1'b0, rem_r}) begin
            rem_r <= rem_r - d_r[WIDTH-1:0];
            tn_r  <= tn_r - t1_sh;
          end
          if (k_r == '0) begin
            state_r <= ST_NEXT;
          end else begin
            d_r <= d_r >> 1;
            k_r <= k_r - CW'(1);
          end
        end
        ST_NEXT: begin
          r0_r    <= r1_r;
          r1_r    <= rem_r;
          t0_r    <= t1_r;
          t1_r    <= tn_r;
          state_r <= ST_SETUP;
        end
        ST_FIX: begin
          if (r0_r != WIDTH'(1)) begin
            err_r   <= 1'b1;
            state_r <= ST_DONE;
          end else if (mode_r == MODE_INV) begin
            res_r   <= inv_v;
            state_r <= ST_DONE;
          end else begin
            sb_r    <= inv_v;
            p_r     <= '0;
            cnt_r   <= CW'(WIDTH - 1);
            state_r <= ST_MDBL;
          end
        end
        ST_MDBL: begin
          p_r     <= (p2 >= {1'b0, mod_r}) ? p2[WIDTH-1:0] - mod_r : p2[WIDTH-1:0];
          state_r <= ST_MADD;
        end
        ST_MADD: begin
          if ((mode_r == MODE_MUL) ? b_r[WIDTH-1] : sb_r[WIDTH-1]) begin
            p_r <= (padd >= {1'b0, mod_r}) ? padd[WIDTH-1:0] - mod_r : padd[WIDTH-1:0];
          end
          b_r  <= {b_r[WIDTH-2:0], 1'b0};
          sb_r <= {sb_r[WIDTH-2:0], 1'b0};
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            cnt_r   <= cnt_r - CW'(1);
            state_r <= ST_MDBL;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_residue_r <= (mode_r == MODE_MUL || (mode_r == MODE_DIV && !err_r))
                             ? p_r : res_r;
            out_err_r     <= err_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_residue_r == '0)
    else $error("error result with nonzero residue");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mod_r != '0 |-> out_residue_r < mod_r)
    else $error("residue not reduced");

  a_euclid_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SETUP |-> r1_r < r0_r)
    else $error("euclid remainders out of order");

  a_mul_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MDBL |-> p_r < mod_r)
    else $error("partial product not reduced");

endmodule
